>>> hdl/prqt_pkg.sv
`default_nettype none
package prqt_pkg;
  localparam int DEPTH = 16;
  localparam int HARD_CAP = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 5;

  typedef enum logic [2:0] {
    REQ_ENQ = 3'd0, REQ_DEQ = 3'd1, REQ_PEEK = 3'd2, REQ_CAN_ID = 3'd3,
    REQ_CAN_AGENT = 3'd4, REQ_EXPIRE = 3'd5, REQ_TICK = 3'd6, REQ_NONE = 3'd7
  } req_t;

  localparam logic [3:0] ST_QUEUED    = 4'd0;
  localparam logic [3:0] ST_FULL      = 4'd1;
  localparam logic [3:0] ST_DEQUEUED  = 4'd2;
  localparam logic [3:0] ST_EMPTY     = 4'd3;
  localparam logic [3:0] ST_CANCELLED = 4'd4;
  localparam logic [3:0] ST_NOTFOUND  = 4'd5;
  localparam logic [3:0] ST_TIMEDOUT  = 4'd6;
  localparam logic [3:0] ST_SUMMARY   = 4'd7;
  localparam logic [3:0] ST_PEEKED    = 4'd8;
  localparam logic [3:0] ST_TICKED    = 4'd9;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] agent;
    logic [7:0]  res_type;
    logic [7:0]  priority_v;
    logic        has_timeout;
    logic [15:0] timeout;
    logic [31:0] stamp;
    logic [31:0] payload;
  } entry_t;

  // chain control broadcast to every cell
  typedef struct packed {
    logic             ins;      // insert new entry in sorted place
    logic             rem;      // remove entry at rem_idx, shift up
    logic [IDX_W-1:0] rem_idx;
  } chain_ctl_t;
endpackage
`default_nettype wire

>>> hdl/prqt_cell.sv
`default_nettype none
module prqt_cell (
  input  wire logic                      clk,
  input  wire prqt_pkg::chain_ctl_t      ctl,
  input  wire logic [prqt_pkg::IDX_W-1:0] my_idx,
  input  wire prqt_pkg::entry_t          new_entry,
  input  wire logic                      occupied, // this cell holds a live entry
  input  wire logic                      prev_ge,  // prior cell holds prio >= new
  input  wire prqt_pkg::entry_t          prev_entry,
  input  wire prqt_pkg::entry_t          next_entry,
  output prqt_pkg::entry_t               entry,
  output logic                           my_ge
);
  import prqt_pkg::*;
  entry_t ent_r, ent_nxt;

  // an empty cell counts as lower priority so insertion stops there
  assign my_ge = occupied && (ent_r.priority_v >= new_entry.priority_v);
  assign entry = ent_r;

  // Insert: cells past the insert point take neighbor above, insert point takes new.
  // Cells beyond held count get garbage, which is never read.
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (!prev_ge) ent_nxt = prev_entry;
      else if (!my_ge) ent_nxt = new_entry;
    end else if (ctl.rem) begin
      if (my_idx >= ctl.rem_idx) ent_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end
endmodule
`default_nettype wire

>>> hdl/priority_request_queue_with_timeouts_core.sv
// Priority request queue with cancel and timeout. Entries sit in a chain of
// 16 cells in service order (priority high first, arrival order among equals).
// Issue a command with start while busy is low; each result appears for one
// cycle with out_valid, and the receiver cannot stall, so collect every strobe.
// The final result of a command has out_last set. Enqueue, dequeue, peek and
// tick never raise busy: the result shows in the cycle after the accepting edge
// and the next command may follow at once. Cancel by id holds busy while it
// walks the chain up to the matching cell, or past every held entry when
// nothing matches; its result follows the last step of that walk. Cancel by
// agent and the expire sweep first count the matches over the held entries,
// so that every result carries the final occupancy, then walk the chain again
// with one result per removed entry, then give the summary result. The chain
// is scanned through one shared compare unit. Write cfg_max_entries only
// while idle.
`default_nettype none
module priority_request_queue_with_timeouts_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [15:0] in_agent,
  input  wire logic [7:0]  in_res_type,
  input  wire logic [7:0]  in_priority_req,
  input  wire logic        in_has_timeout,
  input  wire logic [15:0] in_timeout_ticks,
  input  wire logic [31:0] in_payload,
  input  wire logic [31:0] in_target_id,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_max_entries,
  output logic             out_valid,
  output logic [3:0]       out_status,
  output logic [31:0]      out_req_id,
  output logic [15:0]      out_out_agent,
  output logic [7:0]       out_out_res_type,
  output logic [7:0]       out_out_priority,
  output logic [31:0]      out_out_payload,
  output logic [4:0]       out_match_count,
  output logic [4:0]       out_occupancy,
  output logic             out_is_full,
  output logic             out_last
);
  import prqt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_COUNT, S_SCAN, S_SUM} state_t;

  state_t            state_r;
  logic [2:0]        kind_r;
  logic [15:0]       agent_r;
  logic [31:0]       target_r;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [31:0]       idc_r, now_r;
  logic [4:0]        max_r;
  logic [IDX_W:0]    scan_r;     // cell under test during a sweep
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  fin_r;      // occupancy once the sweep is done
  entry_t            cells [DEPTH];
  logic              ge    [DEPTH];
  entry_t            new_entry;
  chain_ctl_t        ctl;
  logic [CNT_W-1:0]  lim;
  logic              accept;

  // effective limit: min(max_entries, DEPTH, HARD_CAP)
  always_comb begin
    lim = max_r;
    if (32'(lim) > DEPTH) lim = CNT_W'(DEPTH);
    if (32'(lim) > HARD_CAP) lim = CNT_W'(HARD_CAP);
  end

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign new_entry = '{id: idc_r, agent: in_agent, res_type: in_res_type,
                       priority_v: in_priority_req, has_timeout: in_has_timeout,
                       timeout: in_timeout_ticks, stamp: now_r, payload: in_payload};

  // shared compare unit on the cell under scan
  entry_t           sc;
  logic             hit;
  logic [IDX_W-1:0] sidx;
  assign sidx = scan_r[IDX_W-1:0];
  assign sc   = cells[sidx];
  always_comb begin
    unique case (kind_r)
      REQ_CAN_ID:    hit = (sc.id == target_r);
      REQ_CAN_AGENT: hit = (sc.agent == agent_r);
      default:       hit = sc.has_timeout && ((now_r - sc.stamp) >= 32'(sc.timeout));
    endcase
  end

  logic enq_ok, scanning, scan_end, counting, count_end;
  assign enq_ok    = (held_r < lim) && (32'(held_r) < DEPTH);
  assign scanning  = (state_r == S_SCAN);
  assign scan_end  = scanning && (scan_r >= (IDX_W+1)'(held_r));
  assign counting  = (state_r == S_COUNT);
  assign count_end = counting && (scan_r >= (IDX_W+1)'(held_r));

  always_comb begin
    ctl = '0;
    if (accept && req_t'(in_req_type) == REQ_ENQ && enq_ok) ctl.ins = 1'b1;
    if (accept && req_t'(in_req_type) == REQ_DEQ && held_r != '0) ctl.rem = 1'b1;
    if (scanning && !scan_end && hit) begin
      ctl.rem = 1'b1;
      ctl.rem_idx = sidx;
    end
  end

  // Cell chain: each cell sees its neighbors and its predecessor's compare.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t pe, nx;
    logic   pg;
    logic   occ_here;
    assign occ_here = (32'(g) < 32'(held_r));
    if (g == 0) begin : g_first
      assign pe = new_entry;
      assign pg = 1'b1;
    end else begin : g_mid
      // a predecessor beyond the held count never reports prio >= new
      assign pe = cells[g-1];
      assign pg = ge[g-1] && (32'(g) - 1 < 32'(held_r));
    end
    if (g == DEPTH-1) begin : g_last
      assign nx = cells[g];
    end else begin : g_nl
      assign nx = cells[g+1];
    end
    entry_t cur;
    logic   cge;
    prqt_cell u_cell (
      .clk, .ctl, .my_idx(IDX_W'(g)), .new_entry, .occupied(occ_here), .prev_ge(pg),
      .prev_entry(pe), .next_entry(nx), .entry(cur), .my_ge(cge)
    );
    assign cells[g] = cur;
    // treat an empty cell as lower priority so insertion stops there
    assign ge[g] = cge && (32'(g) < 32'(held_r));
  end

  // next held count; the result's entry view is taken before the chain moves
  always_comb begin
    held_nxt = held_r;
    if (ctl.ins) held_nxt = held_r + CNT_W'(1);
    if (ctl.rem) held_nxt = held_r - CNT_W'(1);
  end

  // sweeps report the occupancy left after the whole sweep on every result
  logic [CNT_W-1:0] occ_show;
  assign occ_show = (scanning && kind_r != REQ_CAN_ID) ? fin_r : held_nxt;

  logic             sv;
  logic [3:0]       ss;
  entry_t           se;
  logic             sz, sl;
  logic [CNT_W-1:0] smc;

  always_comb begin
    sv = 1'b0; ss = ST_TICKED; se = cells[0]; sz = 1'b1; sl = 1'b1; smc = '0;
    if (accept) begin
      unique case (req_t'(in_req_type))
        REQ_ENQ: begin
          sv = 1'b1;
          if (enq_ok) begin ss = ST_QUEUED; se = new_entry; sz = 1'b0; end
          else ss = ST_FULL;
        end
        REQ_DEQ, REQ_PEEK: begin
          sv = 1'b1;
          if (held_r == '0) ss = ST_EMPTY;
          else begin
            ss = (req_t'(in_req_type) == REQ_DEQ) ? ST_DEQUEUED : ST_PEEKED;
            sz = 1'b0;
          end
        end
        REQ_TICK: begin sv = 1'b1; ss = ST_TICKED; end
        default: ;
      endcase
    end else if (scanning) begin
      se = sc;
      if (scan_end) begin
        if (kind_r == REQ_CAN_ID) begin sv = 1'b1; ss = ST_NOTFOUND; end
      end else if (hit) begin
        sv = 1'b1; sz = 1'b0;
        ss = (kind_r == REQ_EXPIRE) ? ST_TIMEDOUT : ST_CANCELLED;
        sl = (kind_r == REQ_CAN_ID);
      end
    end else if (state_r == S_SUM) begin
      sv = 1'b1; ss = ST_SUMMARY; smc = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
      idc_r   <= '0;
      now_r   <= '0;
      max_r   <= 5'd16;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_max_entries;
      held_r    <= held_nxt;
      out_valid <= sv;
      if (ctl.ins) idc_r <= idc_r + 32'd1;
      if (accept && req_t'(in_req_type) == REQ_TICK) now_r <= now_r + 32'd1;
      unique case (state_r)
        S_IDLE: if (accept && (req_t'(in_req_type) == REQ_CAN_ID ||
                               req_t'(in_req_type) == REQ_CAN_AGENT ||
                               req_t'(in_req_type) == REQ_EXPIRE)) begin
          state_r <= (req_t'(in_req_type) == REQ_CAN_ID) ? S_SCAN : S_COUNT;
          kind_r  <= in_req_type;
          agent_r <= in_agent;
          target_r <= in_target_id;
          scan_r  <= '0;
          cnt_r   <= '0;
          fin_r   <= held_r;
        end
        S_COUNT: begin
          // count the matches first, then rewind for the removal pass
          if (count_end) begin
            state_r <= S_SCAN;
            scan_r  <= '0;
          end else begin
            if (hit) fin_r <= fin_r - CNT_W'(1);
            scan_r <= scan_r + (IDX_W+1)'(1);
          end
        end
        S_SCAN: begin
          // hold the index on a hit: the next entry shifts into this cell
          if (scan_end) state_r <= (kind_r == REQ_CAN_ID) ? S_IDLE : S_SUM;
          else if (hit) begin
            cnt_r <= cnt_r + CNT_W'(1);
            if (kind_r == REQ_CAN_ID) state_r <= S_IDLE;
          end else scan_r <= scan_r + (IDX_W+1)'(1);
        end
        S_SUM: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // fullness against the limit as it stands when the transaction is taken
  always_ff @(posedge clk) begin
    out_status       <= ss;
    out_req_id       <= sz ? '0 : se.id;
    out_out_agent    <= sz ? '0 : se.agent;
    out_out_res_type <= sz ? '0 : se.res_type;
    out_out_priority <= sz ? '0 : se.priority_v;
    out_out_payload  <= sz ? '0 : se.payload;
    out_match_count  <= smc;
    out_last         <= sl;
    out_occupancy    <= occ_show;
    out_is_full      <= (occ_show >= lim);
  end

  property p_no_overfill;
    @(posedge clk) disable iff (!rst_n) 32'(held_r) <= DEPTH;
  endproperty
  a_no_overfill: assert property (p_no_overfill) else $error("held count above depth");

  property p_busy_no_ins;
    @(posedge clk) disable iff (!rst_n) busy |-> !ctl.ins;
  endproperty
  a_busy_no_ins: assert property (p_busy_no_ins) else $error("insert during sweep");

  property p_sum_last;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && out_status == ST_SUMMARY) |-> out_last;
  endproperty
  a_sum_last: assert property (p_sum_last) else $error("summary not last");
endmodule
`default_nettype wire
